// ===== hdl/ede_pkg.sv =====
// Shared types and constants for the edit distance engine.
`default_nettype none

package ede_pkg;

  // Payload widths fixed by the interface.
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int DIST_W = 6;

  // Default word capacity in characters.
  localparam int MAX_LEN_DEF = 32;

  // Largest distance the result field can carry; larger values saturate.
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Command codes carried on the cmd field.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

endpackage

`default_nettype wire

// ===== hdl/edit_distance_engine.sv =====
// Edit distance engine: two word stores and an iterative one-row DP walker.
// Load beats (cmd 0 or 1) leave the block in idle, so it stays ready for further beats.
// A compute beat first writes row zero for j in 0..n2, then for each of the n1 rows runs a
// row start and, per cell, a read step and an update step in the shared cell unit, then a finish step.
// The result sits in an output register; loads are taken while it waits to be taken.
// Reset clears lengths, drop flag, sequencer and output valid; memories and overflow output are not cleared.
`default_nettype none

module edit_distance_engine #(
  parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [ede_pkg::CMD_W-1:0]  cmd_i,
  input  wire logic [ede_pkg::CHAR_W-1:0] char_code_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [ede_pkg::DIST_W-1:0]      distance_o,
  output logic                            overflow_o
);

  import ede_pkg::*;

  // Length counters hold 0..MAX_LEN; cost cells never exceed MAX_LEN either.
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW    = LEN_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_READ,
    ST_CELL,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  logic [LEN_W-1:0] len_a_q, len_a_d;
  logic [LEN_W-1:0] len_b_q, len_b_d;
  logic             drop_q, drop_d;
  logic [LEN_W-1:0] i_q, i_d;
  logic [LEN_W-1:0] j_q, j_d;
  logic [CW-1:0]    diag_q, diag_d;
  logic [CW-1:0]    left_q, left_d;
  logic [CW-1:0]    last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic             ovf_q, ovf_d;

  // Word and cost memories with registered read data.
  logic [CHAR_W-1:0] first_word  [MAX_LEN];
  logic [CHAR_W-1:0] second_word [MAX_LEN];
  logic [CW-1:0]     cost_row    [MAX_LEN+1];
  logic [CHAR_W-1:0] fw_data_q, sw_data_q;
  logic [CW-1:0]     up_data_q;

  logic              fw_we, sw_we, cr_we;
  logic              fw_re, sw_re, cr_re;
  logic [AW-1:0]     fw_addr, sw_addr;
  logic [LEN_W-1:0]  cr_waddr, cr_raddr;
  logic [CW-1:0]     cr_wdata;

  logic              in_fire;
  logic              sub;
  logic [CW:0]       up_inc, left_inc, diag_add, min_ul;
  logic [CW-1:0]     cell_val;
  logic [31:0]       last_ext;
  logic [DIST_W-1:0] dist_sat;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign overflow_o  = ovf_q;

  // Shared cell unit: min of up + 1, left + 1 and diagonal + mismatch.
  always_comb begin
    sub      = (fw_data_q != sw_data_q);
    up_inc   = {1'b0, up_data_q} + (CW+1)'(1);
    left_inc = {1'b0, left_q} + (CW+1)'(1);
    diag_add = {1'b0, diag_q} + (CW+1)'(sub);
    min_ul   = (up_inc < left_inc) ? up_inc : left_inc;
    cell_val = (diag_add < min_ul) ? diag_add[CW-1:0] : min_ul[CW-1:0];
  end

  // Distance saturates to the field's largest value.
  always_comb begin
    last_ext = 32'(last_q);
    dist_sat = (last_ext > 32'(DIST_MAX)) ? DIST_MAX : last_ext[DIST_W-1:0];
  end

  // Sequencer next-state logic.
  always_comb begin
    state_d     = state_q;
    len_a_d     = len_a_q;
    len_b_d     = len_b_q;
    drop_d      = drop_q;
    i_d         = i_q;
    j_d         = j_q;
    diag_d      = diag_q;
    left_d      = left_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    dist_d      = dist_q;
    ovf_d       = ovf_q;
    fw_we       = 1'b0;
    sw_we       = 1'b0;
    cr_we       = 1'b0;
    fw_re       = 1'b0;
    sw_re       = 1'b0;
    cr_re       = 1'b0;
    fw_addr     = len_a_q[AW-1:0];
    sw_addr     = len_b_q[AW-1:0];
    cr_waddr    = j_q;
    cr_raddr    = j_q;
    cr_wdata    = j_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd_e'(cmd_i))
            CMD_LOAD_A: begin
              if (len_a_q < LEN_W'(MAX_LEN)) begin
                fw_we   = 1'b1;
                len_a_d = len_a_q + LEN_W'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            CMD_LOAD_B: begin
              if (len_b_q < LEN_W'(MAX_LEN)) begin
                sw_we   = 1'b1;
                len_b_d = len_b_q + LEN_W'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            CMD_COMPUTE: begin
              j_d     = '0;
              state_d = ST_INIT;
            end
            CMD_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end

      // Row zero: cost_row[j] = j for j in 0..n2.
      ST_INIT: begin
        cr_we    = 1'b1;
        cr_waddr = j_q;
        cr_wdata = j_q;
        last_d   = j_q;
        if (j_q == len_b_q) begin
          if (len_a_q == '0) begin
            state_d = ST_DONE;
          end else begin
            i_d     = LEN_W'(1);
            state_d = ST_ROW;
          end
        end else begin
          j_d = j_q + LEN_W'(1);
        end
      end

      // Start of row i: fetch the row's character and set the first cell.
      ST_ROW: begin
        fw_re    = 1'b1;
        fw_addr  = AW'(i_q - LEN_W'(1));
        cr_we    = 1'b1;
        cr_waddr = '0;
        cr_wdata = i_q;
        last_d   = i_q;
        left_d   = i_q;
        diag_d   = i_q - LEN_W'(1);
        if (len_b_q == '0) begin
          if (i_q == len_a_q) begin
            state_d = ST_DONE;
          end else begin
            i_d = i_q + LEN_W'(1);
          end
        end else begin
          j_d     = LEN_W'(1);
          state_d = ST_READ;
        end
      end

      // Fetch the column character and the cell above.
      ST_READ: begin
        sw_re    = 1'b1;
        sw_addr  = AW'(j_q - LEN_W'(1));
        cr_re    = 1'b1;
        cr_raddr = j_q;
        state_d  = ST_CELL;
      end

      // Update one cell and step along the row.
      ST_CELL: begin
        cr_we    = 1'b1;
        cr_waddr = j_q;
        cr_wdata = cell_val;
        diag_d   = up_data_q;
        left_d   = cell_val;
        last_d   = cell_val;
        if (j_q == len_b_q) begin
          if (i_q == len_a_q) begin
            state_d = ST_DONE;
          end else begin
            i_d     = i_q + LEN_W'(1);
            state_d = ST_ROW;
          end
        end else begin
          j_d     = j_q + LEN_W'(1);
          state_d = ST_READ;
        end
      end

      // Hand the result to the output register and empty both words.
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          dist_d      = dist_sat;
          ovf_d       = drop_q;
          len_a_d     = '0;
          len_b_d     = '0;
          drop_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer state, word lengths, drop flag and output valid, with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_a_q     <= '0;
      len_b_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_a_q     <= len_a_d;
      len_b_q     <= len_b_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    diag_q <= diag_d;
    left_q <= left_d;
    last_q <= last_d;
    dist_q <= dist_d;
    ovf_q  <= ovf_d;
  end

  // Memory write ports.
  always_ff @(posedge clk_i) begin
    if (fw_we) begin
      first_word[fw_addr] <= char_code_i;
    end
    if (sw_we) begin
      second_word[sw_addr] <= char_code_i;
    end
    if (cr_we) begin
      cost_row[cr_waddr] <= cr_wdata;
    end
  end

  // Memory read ports with registered data.
  always_ff @(posedge clk_i) begin
    if (fw_re) begin
      fw_data_q <= first_word[fw_addr];
    end
    if (sw_re) begin
      sw_data_q <= second_word[sw_addr];
    end
    if (cr_re) begin
      up_data_q <= cost_row[cr_raddr];
    end
  end

  // Word lengths never pass the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_a_q <= LEN_W'(MAX_LEN)) && (len_b_q <= LEN_W'(MAX_LEN)))
    else $error("word length beyond capacity");

  // Cells are only updated inside the loaded word bounds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CELL) |-> (j_q != '0) && (j_q <= len_b_q) &&
                             (i_q != '0) && (i_q <= len_a_q))
    else $error("cell index outside word bounds");

  // A compute beat takes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (cmd_i == CMD_COMPUTE)) |=> !in_ready_o)
    else $error("compute beat did not start the walk");

  // Finishing a compute presents a result and empties both words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && (!out_valid_q || out_ready_i)) |=>
      out_valid_o && (len_a_q == '0) && (len_b_q == '0) && !drop_q)
    else $error("finish did not emit and clear");

endmodule

`default_nettype wire
